// ===== rtl/tplru_pkg.sv =====
package tplru_pkg;

  // Set geometry
  localparam int WAYS      = 8;
  localparam int TAG_WIDTH = 32;

  localparam int WAY_W  = $clog2(WAYS);   // bits of a way index
  localparam int NODE_W = WAY_W + 1;      // heap node number, root is 1

  // Field widths of the transfer payload
  localparam int OP_W       = 2;
  localparam int TAG_IN_W   = 32;
  localparam int DATA_W     = 32;
  localparam int WAY_SEL_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_INV_WAY = 2'd2,
    OP_INV_TAG = 2'd3
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // capture the input transfer
    logic match;     // register tag compare, free-way search and victim walk
    logic update;    // write the set and load the output register
  } tplru_cmd_t;

endpackage

// ===== rtl/tplru_ctrl.sv =====
module tplru_ctrl
  import tplru_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output tplru_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_take;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_UPDATE) && out_free));
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.load_in = in_take;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = in_take ? S_MATCH : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tplru_dpath.sv =====
module tplru_dpath
  import tplru_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tplru_cmd_t                  cmd_i,
  input  logic        [OP_W-1:0]      op_i,
  input  logic        [TAG_IN_W-1:0]  tag_i,
  input  logic signed [DATA_W-1:0]    write_data_i,
  input  logic        [WAY_SEL_W-1:0] way_select_i,
  output logic                        found_o,
  output logic        [WAY_SEL_W-1:0] way_o,
  output logic signed [DATA_W-1:0]    read_data_o,
  output logic                        evicted_o
);

  // Set contents
  logic [TAG_WIDTH-1:0]     tags_q  [WAYS];
  logic signed [DATA_W-1:0] data_q  [WAYS];
  logic [WAYS-1:0]          valid_q, valid_d;
  logic [WAYS-2:0]          tree_q, tree_d;

  // Captured transfer
  op_e                      op_q;
  logic [TAG_WIDTH-1:0]     tag_q;
  logic signed [DATA_W-1:0] wdata_q;
  logic [WAY_SEL_W-1:0]     wsel_q;

  // Match stage results
  logic             hit_q, hit_c;
  logic [WAY_W-1:0] hit_way_q, hit_way_c;
  logic             free_q, free_c;
  logic [WAY_W-1:0] free_way_q, free_way_c;
  logic [WAY_W-1:0] victim_q, victim_c;

  // Update stage
  logic [WAY_W-1:0]     tgt;
  logic                 wr_tag, wr_data, promote;
  logic                 found_d, evicted_d;
  logic [WAY_SEL_W-1:0] way_d;
  logic signed [DATA_W-1:0] rdata_d;

  // Output register
  logic                 found_q, evicted_q;
  logic [WAY_SEL_W-1:0] way_q;
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= op_e'(op_i);
      tag_q   <= tag_i[TAG_WIDTH-1:0];
      wdata_q <= write_data_i;
      wsel_q  <= way_select_i;
    end
  end

  // Compare all tags, find the first free way and walk the tree
  always_comb begin
    logic [NODE_W-1:0] node;
    hit_c      = 1'b0;
    hit_way_c  = '0;
    free_c     = 1'b0;
    free_way_c = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_q[i] && (tags_q[i] == tag_q)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(i);
      end
      if (!valid_q[i]) begin
        free_c     = 1'b1;
        free_way_c = WAY_W'(i);
      end
    end
    node = NODE_W'(1);
    for (int l = 0; l < WAY_W; l++) begin
      node = {node[NODE_W-2:0], tree_q[WAY_W'(node - NODE_W'(1))]};
    end
    victim_c = node[WAY_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      hit_q      <= hit_c;
      hit_way_q  <= hit_way_c;
      free_q     <= free_c;
      free_way_q <= free_way_c;
      victim_q   <= victim_c;
    end
  end

  // Decide the access and its result
  always_comb begin
    logic [NODE_W-1:0] leaf;
    logic [NODE_W-1:0] anc;
    valid_d   = valid_q;
    tree_d    = tree_q;
    tgt       = hit_way_q;
    wr_tag    = 1'b0;
    wr_data   = 1'b0;
    promote   = 1'b0;
    found_d   = 1'b0;
    evicted_d = 1'b0;
    way_d     = '0;
    rdata_d   = '0;
    anc       = '0;
    case (op_q)
      OP_INSERT: begin
        wr_data = 1'b1;
        promote = 1'b1;
        if (hit_q) begin
          found_d = 1'b1;
        end else begin
          tgt       = free_q ? free_way_q : victim_q;
          evicted_d = !free_q;
          wr_tag    = 1'b1;
          valid_d[tgt] = 1'b1;
        end
        way_d = WAY_SEL_W'(tgt);
      end
      OP_LOOKUP: begin
        if (hit_q) begin
          found_d = 1'b1;
          way_d   = WAY_SEL_W'(hit_way_q);
          rdata_d = data_q[hit_way_q];
        end
      end
      OP_INV_WAY: begin
        way_d = wsel_q;
        if (int'(wsel_q) < WAYS) begin
          found_d = 1'b1;
          valid_d[WAY_W'(wsel_q)] = 1'b0;
        end
      end
      OP_INV_TAG: begin
        if (hit_q) begin
          found_d = 1'b1;
          way_d   = WAY_SEL_W'(hit_way_q);
          valid_d[hit_way_q] = 1'b0;
        end
      end
      default: ;
    endcase
    // point every ancestor away from the target way
    leaf = {1'b1, tgt};
    if (promote) begin
      for (int l = 0; l < WAY_W; l++) begin
        anc = leaf >> (l + 1);
        tree_d[WAY_W'(anc - NODE_W'(1))] = !leaf[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      tree_q  <= '0;
    end else if (cmd_i.update) begin
      valid_q <= valid_d;
      tree_q  <= tree_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (wr_tag) begin
        tags_q[tgt] <= tag_q;
      end
      if (wr_data) begin
        data_q[tgt] <= wdata_q;
      end
      found_q   <= found_d;
      evicted_q <= evicted_d;
      way_q     <= way_d;
      rdata_q   <= rdata_d;
    end
  end

  assign found_o     = found_q;
  assign evicted_o   = evicted_q;
  assign way_o       = way_q;
  assign read_data_o = rdata_q;

endmodule

// ===== rtl/tree_plru_cache_set_unit.sv =====
// One set of a set-associative cache: WAYS lines of tag, data word and valid
// bit, with tree pseudo-LRU replacement over WAYS-1 tree bits. Each input
// transfer is an insert, a lookup, an invalidate by way or an invalidate by
// tag, and yields exactly one output transfer. An access has a match cycle
// that compares every tag, finds the lowest free way and walks the tree to
// the victim, then an update cycle that writes the set, promotes the way on
// an insert and loads the output register. The next input transfer is taken
// in that update cycle, so a new transfer is taken while the previous one
// completes; the update cycle waits while a previous result is held stalled
// in the output register. After reset all lines are invalid and the tree
// bits are clear; there is no clearing pass.
module tree_plru_cache_set_unit
  import tplru_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic        [OP_W-1:0]      op_i,
  input  logic        [TAG_IN_W-1:0]  tag_i,
  input  logic signed [DATA_W-1:0]    write_data_i,
  input  logic        [WAY_SEL_W-1:0] way_select_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic        [WAY_SEL_W-1:0] way_o,
  output logic signed [DATA_W-1:0]    read_data_o,
  output logic                        evicted_o
);

  tplru_cmd_t cmd;

  // Sequence each transfer: capture, match, update
  tplru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Hold the set, the tree bits and the output register
  tplru_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_i),
    .tag_i        (tag_i),
    .write_data_i (write_data_i),
    .way_select_i (way_select_i),
    .found_o      (found_o),
    .way_o        (way_o),
    .read_data_o  (read_data_o),
    .evicted_o    (evicted_o)
  );

  // A taken request always spends its match cycle, so stall follows
  a_match_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken without a match cycle");

  // Eviction only happens on an insert miss
  a_evict_excl_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> !found_o)
    else $error("eviction reported together with a hit");

  // Read data is returned only for a hit
  a_rdata_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_data_o != '0)) |-> found_o)
    else $error("read data without a hit");

endmodule
